FILE: rtl/b64_pkg.sv
package b64_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [6:0] PAD_CHAR = 7'h3D;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } in_word_t;

    typedef struct packed {
        logic [6:0] out_char;
        logic       final_char;
    } out_word_t;

    // Up to four characters produced by one input byte.
    typedef struct packed {
        logic [3:0][6:0] chars;
        logic [1:0]      last_idx;
        logic            fin;
    } job_t;

    // Standard base64 alphabet.
    function automatic logic [6:0] sextet_char(input logic [5:0] v);
        logic [6:0] ch;
        if (v < 6'd26) begin
            ch = 7'h41 + {1'b0, v};
        end else if (v < 6'd52) begin
            ch = 7'h61 + {1'b0, v} - 7'd26;
        end else if (v < 6'd62) begin
            ch = 7'h30 + {1'b0, v} - 7'd52;
        end else if (v == 6'd62) begin
            ch = 7'h2B;
        end else begin
            ch = 7'h2F;
        end
        return ch;
    endfunction

endpackage

FILE: rtl/b64_front.sv
module b64_front
    import b64_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    input  in_word_t in_data,
    input  logic     push_ready,
    output logic     push_valid,
    output job_t     push_job
);

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_SECOND,
        PH_THIRD
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [3:0] carry_reg, carry_next;
    job_t       job;
    logic [7:0] b;
    logic       fin;

    assign b          = in_data.data_byte;
    assign fin        = in_data.final_byte;
    assign push_valid = in_valid;
    assign push_job   = job;

    // Classify the byte by group position and build its character list.
    always_comb begin
        job        = '0;
        phase_next = phase_reg;
        carry_next = carry_reg;
        unique case (phase_reg)
            PH_SECOND: begin
                job.chars[0] = sextet_char({carry_reg[1:0], b[7:4]});
                if (fin) begin
                    job.chars[1] = sextet_char({b[3:0], 2'b00});
                    job.chars[2] = PAD_CHAR;
                    job.last_idx = 2'd2;
                    job.fin      = 1'b1;
                    phase_next   = PH_FIRST;
                    carry_next   = 4'd0;
                end else begin
                    job.last_idx = 2'd0;
                    phase_next   = PH_THIRD;
                    carry_next   = b[3:0];
                end
            end
            PH_THIRD: begin
                job.chars[0] = sextet_char({carry_reg, b[7:6]});
                job.chars[1] = sextet_char(b[5:0]);
                job.last_idx = 2'd1;
                job.fin      = fin;
                phase_next   = PH_FIRST;
                carry_next   = 4'd0;
            end
            default: begin
                job.chars[0] = sextet_char(b[7:2]);
                if (fin) begin
                    job.chars[1] = sextet_char({b[1:0], 4'b0000});
                    job.chars[2] = PAD_CHAR;
                    job.chars[3] = PAD_CHAR;
                    job.last_idx = 2'd3;
                    job.fin      = 1'b1;
                    phase_next   = PH_FIRST;
                    carry_next   = 4'd0;
                end else begin
                    job.last_idx = 2'd0;
                    phase_next   = PH_SECOND;
                    carry_next   = {2'b00, b[1:0]};
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_FIRST;
            carry_reg <= 4'd0;
        end else if (in_valid && push_ready) begin
            phase_reg <= phase_next;
            carry_reg <= carry_next;
        end
    end

endmodule

FILE: rtl/b64_queue.sv
module b64_queue
    import b64_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_job,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_job
);

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

FILE: rtl/b64_back.sv
module b64_back
    import b64_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      head_valid,
    input  job_t      head_job,
    output logic      head_pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    logic       m_valid_reg, m_valid_next;
    out_word_t  m_data_reg, m_data_next;
    logic [1:0] idx_reg, idx_next;
    logic       load, last;

    assign load     = head_valid && (!m_valid_reg || m_ready);
    assign last     = (idx_reg == head_job.last_idx);
    assign head_pop = load && last;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        idx_next     = idx_reg;
        if (load) begin
            m_valid_next           = 1'b1;
            m_data_next.out_char   = head_job.chars[idx_reg];
            m_data_next.final_char = head_job.fin && last;
            idx_next               = last ? 2'd0 : idx_reg + 2'd1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            idx_reg     <= 2'd0;
        end else begin
            m_valid_reg <= m_valid_next;
            idx_reg     <= idx_next;
        end
        m_data_reg <= m_data_next;
    end

endmodule

FILE: rtl/base64_stream_encoder.sv
// Streaming base64 encoder, standard alphabet with '=' padding.
// Input channel (s_valid/s_ready/s_data): one source byte per word, with
// final_byte high on the last byte of a message.
// Output channel (m_valid/m_ready/m_data): one ASCII character per word,
// with final_char high on the last character of the encoded message.
// Each byte yields one or two characters; a final byte that ends a group
// early also yields the partial character and padding, up to four
// characters in all. The first character of a byte passes the queue
// entry and then the output register after the byte is accepted. The
// output register drains one character per cycle while m_ready is high,
// which sets throughput: each character of a byte takes its own slot.
// The front stage tracks group position and carried bits and hands a
// character list for each byte to a 2-entry queue; the back stage walks
// that list into the output register.
// Reset (aresetn low, synchronous) drops any partial group, empties the
// queue and clears m_valid. When the receiver stalls, the output word
// holds, the queue fills, and s_ready drops once both entries are taken.
module base64_stream_encoder
    import b64_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    logic push_valid, push_ready;
    job_t push_job;
    logic head_valid, head_pop;
    job_t head_job;

    // Accept a byte whenever the queue has room.
    assign s_ready = push_ready;

    b64_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_data    (s_data),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_job   (push_job)
    );

    // Decouple classification from character output.
    b64_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (head_valid),
        .pop_ready  (head_pop),
        .pop_job    (head_job)
    );

    // Emit one character per cycle while m_ready holds; advance to the next list on the last.
    b64_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_job   (head_job),
        .head_pop   (head_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

FILE: rtl/b64_checker.sv
module b64_checker
    import b64_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_word_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_word_t m_data
);

    // Output word holds while stalled.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("output word changed while stalled");

    // Input word holds while the block is not ready.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input word changed while waiting");

    // Reset clears the output and leaves the queue ready to accept.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("state not cleared by reset");

    // Every character is from the alphabet or is padding.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |->
            (m_data.out_char >= 7'h41 && m_data.out_char <= 7'h5A) ||
            (m_data.out_char >= 7'h61 && m_data.out_char <= 7'h7A) ||
            (m_data.out_char >= 7'h30 && m_data.out_char <= 7'h39) ||
            m_data.out_char == 7'h2B || m_data.out_char == 7'h2F ||
            m_data.out_char == PAD_CHAR)
        else $error("character outside the base64 alphabet");

    // A byte accepted into an idle block shows output once it has passed the queue entry and the output register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> ##1 m_valid)
        else $error("output missing after accepted byte");

endmodule

bind base64_stream_encoder b64_checker u_b64_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
